// ===== hdl/c2c_pkg.sv =====
// Shared request and status codes for the COO to CSR converter.
package c2c_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 4096;
    localparam int WEIGHT_BITS  = 32;

    typedef enum logic [2:0] {
        REQ_CLEAR    = 3'd0,
        REQ_LOAD     = 3'd1,
        REQ_BUILD    = 3'd2,
        REQ_OUT_OFF  = 3'd3,
        REQ_OUT_ENT  = 3'd4,
        REQ_IN_OFF   = 3'd5,
        REQ_IN_ENT   = 3'd6,
        REQ_NONE     = 3'd7
    } req_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_BUILT = 3'd2,
        ST_RANGE     = 3'd3,
        ST_NO_REV    = 3'd4
    } status_t;

    localparam int unsigned CFG_VERTEX_COUNT  = 0;
    localparam int unsigned CFG_SYMMETRIZE    = 1;
    localparam int unsigned CFG_BUILD_REVERSE = 2;

endpackage

// ===== hdl/coo_to_csr_converter_unit.sv =====
// Top level of the COO to CSR converter: edge store, build sequencer and read port.
//
// Channel   Direction  Payload
// s_axis    in         tdata: req_type[2:0] src[12:3] dst[22:13] weight[54:23] idx[67:55]
// m_axis    out        tdata: status[2:0] read_value[15:3] read_weight[47:16] edge_total[60:48]
// cfg       in         cfg_index, cfg_data (vertex_count, symmetrize, build_reverse)
//
// Loads, clears and unused requests pass through accept, store write and result;
// reads pass through accept, memory read, check and result.
// A build runs symmetrize (if enabled), vertex clear, degree count, prefix sum and scatter,
// and a second prefix sum and scatter for the in-edges with build_reverse.
// Reset clears the edge count and the built flag and restores the configuration defaults; no memory is cleared.
// The input stalls while an item is in work or its result waits on m_axis.
module coo_to_csr_converter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // req_type, src_vertex, dst_vertex, edge_weight, read_index (lowest first)
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status, read_value, read_weight, edge_total (lowest first)
    output logic [63:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int MAX_VERTICES = c2c_pkg::MAX_VERTICES;
    localparam int MAX_EDGES    = c2c_pkg::MAX_EDGES;
    localparam int WEIGHT_BITS  = c2c_pkg::WEIGHT_BITS;
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int CW = EW + 1;
    localparam int VC = VW + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_RDW, S_OUT,
        S_SY_RD, S_SY_WR,
        S_CL_V,
        S_DG_RD, S_DG_WT, S_DG_WR,
        S_PF_RD, S_PF_WT, S_PF_WR,
        S_SC_RD, S_SC_WT, S_SC_OF, S_SC_WR,
        S_DONE
    } state_t;

    state_t state_reg;
    logic [CW-1:0] edge_count_reg;
    logic built_reg;
    logic [VC-1:0] vc_cfg_reg;
    logic sym_reg, rev_cfg_reg;
    logic [VC-1:0] lvc_reg;
    logic lrev_reg;
    logic in_pass_reg;
    logic [CW-1:0] i_reg, n_reg;
    logic [VC-1:0] v_reg;
    logic [CW-1:0] acc_reg;
    logic [CW-1:0] tot_o_reg, tot_i_reg;
    logic [2:0] st_reg;
    logic [2:0] req_reg;
    logic [VW-1:0] src_in_reg, dst_in_reg;
    logic [WEIGHT_BITS-1:0] w_in_reg;
    logic [12:0] idx_reg;
    logic [12:0] val_reg;
    logic [31:0] rw_reg;
    logic [VW-1:0] es_reg, ed_reg;
    logic [WEIGHT_BITS-1:0] ew_reg;

    logic [VW-1:0] st_src_mem [MAX_EDGES];
    logic [VW-1:0] st_dst_mem [MAX_EDGES];
    logic [WEIGHT_BITS-1:0] st_w_mem [MAX_EDGES];
    logic [CW-1:0] odeg_mem [MAX_VERTICES];
    logic [CW-1:0] ideg_mem [MAX_VERTICES];
    logic [CW-1:0] ooff_mem [MAX_VERTICES+1];
    logic [CW-1:0] ioff_mem [MAX_VERTICES+1];
    logic [VW-1:0] onb_mem [MAX_EDGES];
    logic [WEIGHT_BITS-1:0] ow_mem [MAX_EDGES];
    logic [VW-1:0] inb_mem [MAX_EDGES];
    logic [WEIGHT_BITS-1:0] iw_mem [MAX_EDGES];

    logic [VW-1:0] rs_q, rd_q;
    logic [WEIGHT_BITS-1:0] rw_q;
    logic [CW-1:0] od_q, id_q, oo_q, io_q, oof_q, iof_q;
    logic [VW-1:0] onb_q, inb_q;
    logic [WEIGHT_BITS-1:0] ow_q, iw_q;

    logic [2:0] req_t_in;
    logic [VW-1:0] src_t, dst_t;
    logic [WEIGHT_BITS-1:0] w_t;
    logic [12:0] idx_t;
    logic accept;
    logic [VC-1:0] vc_sat;

    assign req_t_in = s_axis_tdata[2:0];
    assign src_t = s_axis_tdata[3 +: VW];
    assign dst_t = s_axis_tdata[13 +: VW];
    assign w_t = s_axis_tdata[23 +: WEIGHT_BITS];
    assign idx_t = s_axis_tdata[67:55];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata = {3'd0, 13'(edge_count_reg), rw_reg, val_reg, st_reg};

    always_comb
    begin
        if (vc_cfg_reg == '0)
            vc_sat = VC'(1);
        else if (32'(vc_cfg_reg) > MAX_VERTICES)
            vc_sat = VC'(MAX_VERTICES);
        else
            vc_sat = vc_cfg_reg;
    end

    // Edge index used by the store read port in each phase.
    logic [EW-1:0] st_ra;
    logic [VW-1:0] vaddr;
    logic in_range;
    logic [VW-1:0] oda, ida;

    assign st_ra = i_reg[EW-1:0];
    assign in_range = (32'(es_reg) < 32'(lvc_reg)) && (32'(ed_reg) < 32'(lvc_reg));
    assign vaddr = v_reg[VW-1:0];
    assign oda = (state_reg == S_DG_WT) ? rs_q : ((state_reg == S_SC_OF) ? es_reg : vaddr);
    assign ida = (state_reg == S_DG_WT) ? rd_q : ((state_reg == S_SC_OF) ? ed_reg : vaddr);

    always_ff @(posedge clk)
    begin
        rs_q <= st_src_mem[st_ra];
        rd_q <= st_dst_mem[st_ra];
        rw_q <= st_w_mem[st_ra];
        od_q <= odeg_mem[oda];
        id_q <= ideg_mem[ida];
        oof_q <= ooff_mem[es_reg];
        iof_q <= ioff_mem[ed_reg];
        oo_q <= ooff_mem[idx_reg[VW:0] > VC'(MAX_VERTICES) ? '0 : idx_reg[VW:0]];
        io_q <= ioff_mem[idx_reg[VW:0] > VC'(MAX_VERTICES) ? '0 : idx_reg[VW:0]];
        onb_q <= onb_mem[idx_reg[EW-1:0]];
        ow_q <= ow_mem[idx_reg[EW-1:0]];
        inb_q <= inb_mem[idx_reg[EW-1:0]];
        iw_q <= iw_mem[idx_reg[EW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            edge_count_reg <= '0;
            built_reg <= 1'b0;
            vc_cfg_reg <= VC'(1024);
            sym_reg <= 1'b0;
            rev_cfg_reg <= 1'b0;
            lvc_reg <= VC'(1);
            lrev_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    2'(c2c_pkg::CFG_VERTEX_COUNT):  vc_cfg_reg <= VC'(cfg_data);
                    2'(c2c_pkg::CFG_SYMMETRIZE):    sym_reg <= cfg_data[0];
                    2'(c2c_pkg::CFG_BUILD_REVERSE): rev_cfg_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg <= req_t_in;
                        src_in_reg <= src_t;
                        dst_in_reg <= dst_t;
                        w_in_reg <= w_t;
                        idx_reg <= idx_t;
                        st_reg <= c2c_pkg::ST_OK;
                        val_reg <= '0;
                        rw_reg <= '0;
                        if (req_t_in == c2c_pkg::REQ_BUILD)
                        begin
                            n_reg <= edge_count_reg;
                            i_reg <= '0;
                            state_reg <= sym_reg ? S_SY_RD : S_CL_V;
                            v_reg <= '0;
                            lvc_reg <= vc_sat;
                            lrev_reg <= rev_cfg_reg;
                        end
                        else
                            state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    case (req_reg)
                        c2c_pkg::REQ_CLEAR:
                        begin
                            edge_count_reg <= '0;
                            built_reg <= 1'b0;
                            state_reg <= S_OUT;
                        end
                        c2c_pkg::REQ_LOAD:
                        begin
                            if (32'(edge_count_reg) >= MAX_EDGES)
                                st_reg <= c2c_pkg::ST_FULL;
                            else
                            begin
                                st_src_mem[edge_count_reg[EW-1:0]] <= src_in_reg;
                                st_dst_mem[edge_count_reg[EW-1:0]] <= dst_in_reg;
                                st_w_mem[edge_count_reg[EW-1:0]] <= w_in_reg;
                                edge_count_reg <= edge_count_reg + 1'b1;
                                built_reg <= 1'b0;
                            end
                            state_reg <= S_OUT;
                        end
                        c2c_pkg::REQ_NONE: state_reg <= S_OUT;
                        default: state_reg <= S_RDW;
                    endcase
                end
                S_RDW:
                begin
                    state_reg <= S_OUT;
                    if (!built_reg)
                        st_reg <= c2c_pkg::ST_NOT_BUILT;
                    else if ((req_reg == c2c_pkg::REQ_IN_OFF || req_reg == c2c_pkg::REQ_IN_ENT)
                             && !lrev_reg)
                        st_reg <= c2c_pkg::ST_NO_REV;
                    else if (req_reg == c2c_pkg::REQ_OUT_OFF || req_reg == c2c_pkg::REQ_IN_OFF)
                    begin
                        if (32'(idx_reg) > 32'(lvc_reg))
                            st_reg <= c2c_pkg::ST_RANGE;
                        else if (idx_reg == 13'(lvc_reg))
                            val_reg <= 13'(req_reg == c2c_pkg::REQ_IN_OFF ? tot_i_reg : tot_o_reg);
                        else
                            val_reg <= 13'(req_reg == c2c_pkg::REQ_IN_OFF ? io_q : oo_q);
                    end
                    else if (req_reg == c2c_pkg::REQ_OUT_ENT)
                    begin
                        if (32'(idx_reg) >= 32'(tot_o_reg))
                            st_reg <= c2c_pkg::ST_RANGE;
                        else
                        begin
                            val_reg <= 13'(onb_q);
                            rw_reg <= 32'(signed'(ow_q));
                        end
                    end
                    else
                    begin
                        if (32'(idx_reg) >= 32'(tot_i_reg))
                            st_reg <= c2c_pkg::ST_RANGE;
                        else
                        begin
                            val_reg <= 13'(inb_q);
                            rw_reg <= 32'(signed'(iw_q));
                        end
                    end
                end
                S_OUT:
                    if (m_axis_tready)
                        state_reg <= S_IDLE;
                // Symmetrize: read edge i, append reversed copy unless it is a self-loop.
                S_SY_RD:
                    if (i_reg == n_reg)
                        state_reg <= S_CL_V;
                    else
                        state_reg <= S_SY_WR;
                S_SY_WR:
                begin
                    if (rs_q != rd_q)
                    begin
                        if (32'(edge_count_reg) >= MAX_EDGES)
                            st_reg <= c2c_pkg::ST_FULL;
                        else
                        begin
                            st_src_mem[edge_count_reg[EW-1:0]] <= rd_q;
                            st_dst_mem[edge_count_reg[EW-1:0]] <= rs_q;
                            st_w_mem[edge_count_reg[EW-1:0]] <= rw_q;
                            edge_count_reg <= edge_count_reg + 1'b1;
                        end
                    end
                    i_reg <= i_reg + 1'b1;
                    state_reg <= S_SY_RD;
                end
                S_CL_V:
                begin
                    odeg_mem[vaddr] <= '0;
                    ideg_mem[vaddr] <= '0;
                    if (v_reg == lvc_reg - 1'b1)
                    begin
                        i_reg <= '0;
                        in_pass_reg <= 1'b0;
                        state_reg <= S_DG_RD;
                    end
                    else
                        v_reg <= v_reg + 1'b1;
                end
                // Degree count: fetch edge, then read-modify-write counters.
                S_DG_RD:
                begin
                    if (i_reg == edge_count_reg)
                    begin
                        v_reg <= '0;
                        acc_reg <= '0;
                        state_reg <= S_PF_RD;
                    end
                    else
                        state_reg <= S_DG_WT;
                end
                S_DG_WT:
                begin
                    es_reg <= rs_q;
                    ed_reg <= rd_q;
                    state_reg <= S_DG_WR;
                end
                S_DG_WR:
                begin
                    if (in_range)
                    begin
                        odeg_mem[es_reg] <= od_q + 1'b1;
                        if (lrev_reg)
                            ideg_mem[ed_reg] <= id_q + 1'b1;
                    end
                    i_reg <= i_reg + 1'b1;
                    state_reg <= S_DG_RD;
                end
                // Prefix sum: walk vertices, write offset, reset cursor.
                S_PF_RD: state_reg <= S_PF_WT;
                S_PF_WT: state_reg <= S_PF_WR;
                S_PF_WR:
                begin
                    if (in_pass_reg)
                    begin
                        ioff_mem[vaddr] <= acc_reg;
                        acc_reg <= acc_reg + id_q;
                        ideg_mem[vaddr] <= '0;
                    end
                    else
                    begin
                        ooff_mem[vaddr] <= acc_reg;
                        acc_reg <= acc_reg + od_q;
                        odeg_mem[vaddr] <= '0;
                    end
                    if (v_reg == lvc_reg - 1'b1)
                    begin
                        if (in_pass_reg)
                            tot_i_reg <= acc_reg + id_q;
                        else
                            tot_o_reg <= acc_reg + od_q;
                        i_reg <= '0;
                        state_reg <= S_SC_RD;
                    end
                    else
                    begin
                        v_reg <= v_reg + 1'b1;
                        state_reg <= S_PF_RD;
                    end
                end
                // Scatter: cursor memory reused from the cleared degree memory.
                S_SC_RD:
                begin
                    if (i_reg == edge_count_reg)
                    begin
                        if (!in_pass_reg && lrev_reg)
                        begin
                            in_pass_reg <= 1'b1;
                            v_reg <= '0;
                            state_reg <= S_PF_RD;
                            acc_reg <= '0;
                        end
                        else
                            state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_SC_WT;
                end
                S_SC_WT:
                begin
                    es_reg <= rs_q;
                    ed_reg <= rd_q;
                    ew_reg <= rw_q;
                    state_reg <= S_SC_OF;
                end
                S_SC_OF: state_reg <= S_SC_WR;
                S_SC_WR:
                begin
                    if (in_range)
                    begin
                        if (in_pass_reg)
                        begin
                            inb_mem[EW'(iof_q + id_q)] <= es_reg;
                            iw_mem[EW'(iof_q + id_q)] <= ew_reg;
                            ideg_mem[ed_reg] <= id_q + 1'b1;
                        end
                        else
                        begin
                            onb_mem[EW'(oof_q + od_q)] <= ed_reg;
                            ow_mem[EW'(oof_q + od_q)] <= ew_reg;
                            odeg_mem[es_reg] <= od_q + 1'b1;
                        end
                    end
                    i_reg <= i_reg + 1'b1;
                    state_reg <= S_SC_RD;
                end
                S_DONE:
                begin
                    built_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while a result waits");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        32'(edge_count_reg) <= MAX_EDGES)
        else $error("edge count beyond capacity");
    a_load_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD && req_reg == c2c_pkg::REQ_LOAD && 32'(edge_count_reg) < MAX_EDGES)
        |=> built_reg == 1'b0)
        else $error("built flag kept after load");
`endif

endmodule
